### src/psy_pkg.sv
// Shared types and constants for the point sort by y block.
package psy_pkg;

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
    } t_point_in;

    typedef struct packed {
        logic signed [31:0] sorted_x;
        logic signed [31:0] sorted_y;
        logic               final_point;
    } t_point_out;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_WAIT,
        S_SWAP_A,
        S_SWAP_B,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        WR_INPUT,
        WR_MIN,
        WR_CUR
    } t_wr_sel;

    typedef struct packed {
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    rd_en;
        logic    scan;
        logic    scan_first;
        logic    emit;
        logic    emit_last;
    } t_dp_cmd;

endpackage

### src/point_sort_by_y.sv
// Top level of the point sorter that orders a set of points by y coordinate.
//
// Usage: the block takes POINTS points, one beat per cycle, at edges where
// start is high and busy is low. Each beat carries a signed Q20.12 x and y.
// After the last point of a set, busy rises and the block runs a selection
// sort on its point memory: pass j reads entries j to POINTS-1, one per cycle
// through the single read port, then swaps two entries: it writes the minimum
// into entry j and then the old entry j where that minimum was found.
// The block then reads the sorted points one per cycle and presents each on
// o_result for exactly one cycle with o_strobe high; final_point marks the
// last one. Results come out one per cycle and the receiver cannot hold
// them off. Busy falls in the cycle the final result is shown, so the next
// set may begin loading right away. A synchronous reset returns the block to
// loading with an empty set; the point memory is not cleared.
module point_sort_by_y #(
    parameter int POINTS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  psy_pkg::t_point_in  i_point,
    output psy_pkg::t_point_out o_result,
    output logic                o_strobe
);
    import psy_pkg::*;

    localparam int IW = $clog2(POINTS);

    t_dp_cmd       cmd;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;

    psy_ctrl #(
        .POINTS (POINTS),
        .IW     (IW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .o_cmd     (cmd),
        .o_wr_addr (wr_addr),
        .o_rd_addr (rd_addr)
    );

    psy_dp #(
        .POINTS (POINTS),
        .IW     (IW)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .i_point   (i_point),
        .o_result  (o_result),
        .o_strobe  (o_strobe)
    );

`ifndef SYNTHESIS
    a_input_write_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wr_en && cmd.wr_sel == WR_INPUT) |-> (start && !busy))
        else $error("input write without an accepted beat");

    a_strobe_follows_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(cmd.emit))
        else $error("result strobe without an emission read");

    a_final_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.final_point |-> o_strobe)
        else $error("final flag outside a result beat");

    a_idle_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.final_point |-> !busy)
        else $error("block still busy at final result");
`endif

endmodule

### src/psy_dp.sv
// Datapath of the point sorter: point memory, running minimum and result register.
module psy_dp #(
    parameter int POINTS = 8,
    parameter int IW     = $clog2(POINTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psy_pkg::t_dp_cmd   i_cmd,
    input  logic [IW-1:0]      i_wr_addr,
    input  logic [IW-1:0]      i_rd_addr,
    input  psy_pkg::t_point_in i_point,
    output psy_pkg::t_point_out o_result,
    output logic               o_strobe
);
    import psy_pkg::*;

    t_point_in     r_mem [POINTS];
    t_point_in     r_rd;
    logic [IW-1:0] r_rd_idx;
    logic          r_scan;
    logic          r_scan_first;
    t_point_in     r_cur;
    t_point_in     r_min;
    logic [IW-1:0] r_best;
    logic          r_out_valid;
    logic          r_final;

    t_point_in     n_wr_data;
    logic [IW-1:0] n_wr_addr;

    always_comb begin
        n_wr_addr = i_wr_addr;
        unique case (i_cmd.wr_sel)
            WR_INPUT: n_wr_data = i_point;
            WR_MIN:   n_wr_data = r_min;
            WR_CUR: begin
                n_wr_data = r_cur;
                n_wr_addr = r_best;
            end
            default:  n_wr_data = i_point;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[n_wr_addr] <= n_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd     <= r_mem[i_rd_addr];
            r_rd_idx <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan       <= 1'b0;
            r_scan_first <= 1'b0;
            r_out_valid  <= 1'b0;
            r_final      <= 1'b0;
        end else begin
            r_scan       <= i_cmd.scan;
            r_scan_first <= i_cmd.scan_first;
            r_out_valid  <= i_cmd.emit;
            r_final      <= i_cmd.emit & i_cmd.emit_last;
        end
    end

    // The last entry with a key at or below the running minimum wins.
    always_ff @(posedge i_clk) begin
        if (r_scan) begin
            if (r_scan_first) begin
                r_cur  <= r_rd;
                r_min  <= r_rd;
                r_best <= r_rd_idx;
            end else if ($signed(r_rd.y_coord) <= $signed(r_min.y_coord)) begin
                r_min  <= r_rd;
                r_best <= r_rd_idx;
            end
        end
    end

    assign o_result.sorted_x    = r_rd.x_coord;
    assign o_result.sorted_y    = r_rd.y_coord;
    assign o_result.final_point = r_final;
    assign o_strobe             = r_out_valid;

endmodule

### src/psy_ctrl.sv
// Controller of the point sorter: load, selection passes and emission sequencing.
module psy_ctrl #(
    parameter int POINTS = 8,
    parameter int IW     = $clog2(POINTS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output psy_pkg::t_dp_cmd o_cmd,
    output logic [IW-1:0]    o_wr_addr,
    output logic [IW-1:0]    o_rd_addr
);
    import psy_pkg::*;

    localparam logic [IW-1:0] LAST      = IW'(POINTS - 1);
    localparam logic [IW-1:0] LAST_PASS = IW'(POINTS - 2);

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_idx   <= '0;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pass    = r_pass;
        o_cmd     = '0;
        o_cmd.wr_sel = WR_INPUT;
        o_wr_addr = r_idx;
        o_rd_addr = r_idx;
        busy      = (r_state != S_LOAD);
        unique case (r_state)
            S_LOAD: begin
                if (start) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_INPUT;
                    if (r_idx == LAST) begin
                        n_state = S_SCAN;
                        n_idx   = '0;
                        n_pass  = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en      = 1'b1;
                o_cmd.scan       = 1'b1;
                o_cmd.scan_first = (r_idx == r_pass);
                if (r_idx == LAST) begin
                    n_state = S_WAIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_WAIT: begin
                n_state = S_SWAP_A;
            end
            S_SWAP_A: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_MIN;
                o_wr_addr    = r_pass;
                n_state      = S_SWAP_B;
            end
            S_SWAP_B: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_CUR;
                if (r_pass == LAST_PASS) begin
                    n_state = S_EMIT;
                    n_idx   = '0;
                end else begin
                    n_state = S_SCAN;
                    n_pass  = r_pass + 1'b1;
                    n_idx   = r_pass + 1'b1;
                end
            end
            S_EMIT: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = (r_idx == LAST);
                if (r_idx == LAST) begin
                    n_state = S_LOAD;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_LOAD;
                n_idx   = '0;
            end
        endcase
    end

endmodule
